/* sv/limit_order_book_matcher_defines.svh */
// Assertion macros shared by the order book RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LOBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LOBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lobm_pkg.sv */
// Shared types and constants of the order book matcher.
// No dependencies.
package lobm_pkg;

  localparam int BOOK_DEPTH = 32;
  localparam int IDX_W      = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

  localparam logic MODE_NEW    = 1'b0;
  localparam logic MODE_CANCEL = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic SIDE_SELL   = 1'b1;
  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef enum logic [2:0] {
    STAT_RESTED    = 3'd0,
    STAT_FILLED    = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_BOOK_FULL = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
  } book_word_t;

  // What the scan is looking for.
  typedef struct packed {
    logic        is_cancel;
    logic        side;
    logic [31:0] id;
    logic [31:0] limit;
  } scan_ctx_t;

  // One slot as seen by the compare unit.
  typedef struct packed {
    logic             valid;
    logic             side;
    logic [IDX_W-1:0] rank;
    logic [31:0]      id;
    logic [31:0]      price;
  } slot_view_t;

  // Current best candidate.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] rank;
    logic [31:0]      price;
  } best_view_t;

endpackage

/* sv/lobm_scan_cmp.sv */
// Compare unit shared by the best-price search and the cancel lookup.
// Depends on lobm_pkg.
module lobm_scan_cmp
  import lobm_pkg::*;
(
  input  scan_ctx_t  ctx_i,
  input  slot_view_t slot_i,
  input  best_view_t best_i,
  output logic       take_o
);

  logic crosses;
  logic price_better;
  logic price_equal;
  logic older;

  always_comb begin
    crosses      = (ctx_i.side == SIDE_BUY) ? (slot_i.price <= ctx_i.limit)
                                            : (slot_i.price >= ctx_i.limit);
    price_better = (ctx_i.side == SIDE_BUY) ? (slot_i.price < best_i.price)
                                            : (slot_i.price > best_i.price);
    price_equal  = (slot_i.price == best_i.price);
    older        = (slot_i.rank < best_i.rank);
    if (ctx_i.is_cancel) begin
      take_o = slot_i.valid && (slot_i.id == ctx_i.id) && (!best_i.found || older);
    end else begin
      take_o = slot_i.valid && (slot_i.side != ctx_i.side) && crosses &&
               (!best_i.found || price_better || (price_equal && older));
    end
  end

endmodule

/* sv/limit_order_book_matcher.sv */
// Top level of the price-time priority order book matcher.
// Depends on lobm_pkg, lobm_scan_cmp and limit_order_book_matcher_defines.svh.
//
// Usage:
// - Request channel: in_valid_i with mode/side/order_id/limit_price/quantity;
//   a request is taken when in_valid_i is high and in_stall_o is low.
//   in_stall_o is high from acceptance until the final result is loaded.
// - Result channel: out_valid_o with the result fields; a result is taken
//   when out_valid_o is high and out_stall_i is low. last_o marks the final
//   result of a request.
// - Every search walks all BOOK_DEPTH slots through one compare unit, one
//   slot per cycle, behind a registered memory read.
// - Steps from one accepted request to the earliest next one, no stalls:
//   cancel: accept, search, decide.
// - New order: a search and a decide per trade, then the completion report
//   when the last trade fills it, otherwise a final search and decide before
//   the completion report; a zero quantity order goes straight to the report.
// - A stalled receiver holds the output register; the sequencer waits in
//   its emit state until the register is free.
// - Reset empties the book at once (valid bits clear); no clearing pass.
module limit_order_book_matcher
  import lobm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic        side_i,
  input  logic [31:0] order_id_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] quantity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [31:0] resting_id_o,
  output logic [31:0] incoming_id_o,
  output logic [31:0] trade_price_o,
  output logic [31:0] trade_qty_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BOOK_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BOOK_DEPTH);

  state_e state_q, state_d;

  // Book storage: payload in memory, bookkeeping in flops.
  book_word_t             mem [BOOK_DEPTH];
  logic [BOOK_DEPTH-1:0]  valid_q;
  logic                   side_q [BOOK_DEPTH];
  logic [IDX_W-1:0]       rank_q [BOOK_DEPTH];
  logic [CNT_W-1:0]       count_q;

  // Request held during processing.
  logic        mode_q, mode_d;
  logic        rside_q, rside_d;
  logic [31:0] id_q, id_d;
  logic [31:0] limit_q, limit_d;
  logic [31:0] qty_q, qty_d;

  // Scan pipeline.
  logic [IDX_W-1:0] scan_rd_q, scan_rd_d;
  logic             issue_q, issue_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  book_word_t       rd_data_q;

  // Best candidate.
  logic             best_found_q, best_found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [IDX_W-1:0] best_rank_q, best_rank_d;
  logic [31:0]      best_id_q, best_id_d;
  logic [31:0]      best_price_q, best_price_d;
  logic [31:0]      best_qty_q, best_qty_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [31:0] rid_q, rid_d;
  logic [31:0] iid_q, iid_d;
  logic [31:0] price_q, price_d;
  logic [31:0] oqty_q, oqty_d;
  logic [2:0]  status_q, status_d;
  logic        last_q, last_d;

  // Book update controls.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  book_word_t       mem_wdata;
  logic             rm_en;
  logic [IDX_W-1:0] rm_idx;
  logic             ins_en;
  logic [IDX_W-1:0] free_idx;

  logic        out_free;
  logic        emit;
  logic        take;
  logic [31:0] fill;
  logic [31:0] rest_left;
  scan_ctx_t   ctx;
  slot_view_t  slot;
  best_view_t  best;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign ctx  = '{is_cancel: mode_q, side: rside_q, id: id_q, limit: limit_q};
  assign slot = '{valid: valid_q[cmp_idx_q], side: side_q[cmp_idx_q],
                  rank: rank_q[cmp_idx_q], id: rd_data_q.id, price: rd_data_q.price};
  assign best = '{found: best_found_q, rank: best_rank_q, price: best_price_q};

  lobm_scan_cmp u_cmp (
    .ctx_i  (ctx),
    .slot_i (slot),
    .best_i (best),
    .take_o (take)
  );

  assign fill      = (qty_q < best_qty_q) ? qty_q : best_qty_q;
  assign rest_left = best_qty_q - fill;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    rside_d      = rside_q;
    id_d         = id_q;
    limit_d      = limit_q;
    qty_d        = qty_q;
    scan_rd_d    = scan_rd_q;
    issue_d      = issue_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = 1'b0;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_rank_d  = best_rank_q;
    best_id_d    = best_id_q;
    best_price_d = best_price_q;
    best_qty_d   = best_qty_q;
    emit         = 1'b0;
    kind_d       = kind_q;
    rid_d        = rid_q;
    iid_d        = iid_q;
    price_d      = price_q;
    oqty_d       = oqty_q;
    status_d     = status_q;
    last_d       = last_q;
    mem_we       = 1'b0;
    mem_waddr    = best_idx_q;
    mem_wdata    = '{id: best_id_q, price: best_price_q, qty: rest_left};
    rm_en        = 1'b0;
    rm_idx       = best_idx_q;
    ins_en       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d       = mode_i;
          rside_d      = side_i;
          id_d         = order_id_i;
          limit_d      = limit_price_i;
          qty_d        = quantity_i;
          scan_rd_d    = '0;
          issue_d      = 1'b1;
          best_found_d = 1'b0;
          state_d      = (mode_i == MODE_CANCEL || quantity_i != '0) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        // Issue one slot read per cycle; compare the slot read last cycle.
        cmp_vld_d = issue_q;
        cmp_idx_d = scan_rd_q;
        if (issue_q) begin
          if (scan_rd_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            scan_rd_d = scan_rd_q + 1'b1;
          end
        end
        if (cmp_vld_q && take) begin
          best_found_d = 1'b1;
          best_idx_d   = cmp_idx_q;
          best_rank_d  = rank_q[cmp_idx_q];
          best_id_d    = rd_data_q.id;
          best_price_d = rd_data_q.price;
          best_qty_d   = rd_data_q.qty;
        end
        if (cmp_vld_q && cmp_idx_q == LAST_IDX) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (mode_q == MODE_CANCEL) begin
            emit     = 1'b1;
            kind_d   = KIND_DONE;
            rid_d    = id_q;
            iid_d    = id_q;
            price_d  = best_found_q ? best_price_q : '0;
            oqty_d   = best_found_q ? best_qty_q : '0;
            status_d = best_found_q ? STAT_CANCELLED : STAT_NOT_FOUND;
            last_d   = 1'b1;
            rm_en    = best_found_q;
            state_d  = ST_IDLE;
          end else if (best_found_q) begin
            // Trade against the best resting order, then search again unless the order is filled.
            emit     = 1'b1;
            kind_d   = KIND_TRADE;
            rid_d    = best_id_q;
            iid_d    = id_q;
            price_d  = best_price_q;
            oqty_d   = fill;
            status_d = STAT_RESTED;
            last_d   = 1'b0;
            qty_d    = qty_q - fill;
            if (rest_left == '0) begin
              rm_en = 1'b1;
            end else begin
              mem_we = 1'b1;
            end
            scan_rd_d    = '0;
            issue_d      = 1'b1;
            best_found_d = 1'b0;
            state_d      = (qty_q == fill) ? ST_FINISH : ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // No search follows; drop any pending issue.
        issue_d = 1'b0;
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KIND_DONE;
          rid_d   = '0;
          iid_d   = id_q;
          price_d = limit_q;
          oqty_d  = qty_q;
          last_d  = 1'b1;
          if (qty_q == '0) begin
            status_d = STAT_FILLED;
          end else if (count_q == FULL_CNT) begin
            status_d = STAT_BOOK_FULL;
          end else begin
            status_d  = STAT_RESTED;
            ins_en    = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = free_idx;
            mem_wdata = '{id: id_q, price: limit_q, qty: qty_q};
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = emit ? 1'b1 : (out_stall_i && out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
      if (rm_en) begin
        valid_q[rm_idx] <= 1'b0;
        count_q         <= count_q - 1'b1;
      end else if (ins_en) begin
        valid_q[free_idx] <= 1'b1;
        count_q           <= count_q + 1'b1;
      end
    end
  end

  // Age ranks and sides: close the gap on removal, append on insert.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (rm_en && valid_q[i] && rank_q[i] > rank_q[rm_idx]) begin
        rank_q[i] <= rank_q[i] - 1'b1;
      end
    end
    if (ins_en) begin
      rank_q[free_idx] <= count_q[IDX_W-1:0];
      side_q[free_idx] <= rside_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    rside_q      <= rside_d;
    id_q         <= id_d;
    limit_q      <= limit_d;
    qty_q        <= qty_d;
    scan_rd_q    <= scan_rd_d;
    cmp_idx_q    <= cmp_idx_d;
    best_found_q <= best_found_d;
    best_idx_q   <= best_idx_d;
    best_rank_q  <= best_rank_d;
    best_id_q    <= best_id_d;
    best_price_q <= best_price_d;
    best_qty_q   <= best_qty_d;
    kind_q       <= kind_d;
    rid_q        <= rid_d;
    iid_q        <= iid_d;
    price_q      <= price_d;
    oqty_q       <= oqty_d;
    status_q     <= status_d;
    last_q       <= last_d;
  end

  // Book memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[scan_rd_q];
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign resting_id_o  = rid_q;
  assign incoming_id_o = iid_q;
  assign trade_price_o = price_q;
  assign trade_qty_o   = oqty_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

`include "limit_order_book_matcher_defines.svh"

  `LOBM_ASSERT_NOW(a_count_matches, 1'b1, count_q == CNT_W'($countones(valid_q)), "count mismatch")
  `LOBM_ASSERT_NOW(a_best_is_live, state_q == ST_DECIDE && best_found_q, valid_q[best_idx_q], "best slot not valid")
  `LOBM_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != ST_IDLE, "accepted request not in work")
  `LOBM_ASSERT_NOW(a_idle_no_cmp, state_q == ST_IDLE, !cmp_vld_q && !issue_q, "scan active while idle")

endmodule
